>>> design/rrh_pkg.sv
// rrh_pkg: shared types and constants for the rectangle range hit counter
// no dependencies; imported by every rrh module and the top level
`default_nettype none
package rrh_pkg;

  localparam int COORD_W  = 32;
  localparam int CNT_W    = 32;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int ACTIVE_W = 7;

  // item kinds; code 3 carries no meaning and is ignored
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
  } rect_t;

  // enables from the sequencer to the storage bank
  typedef struct packed {
    logic rect_we;  // write one rectangle row
    logic cnt_we;   // write one counter
    logic cnt_wb;   // counter write carries the updated count
  } bank_ctl_t;

endpackage
`default_nettype wire

>>> design/rrh_match.sv
// rrh_match: shared containment compare and saturating counter increment
// depends on rrh_pkg
`default_nettype none
module rrh_match (
  input  var rrh_pkg::rect_t                    rect,
  input  logic signed [rrh_pkg::COORD_W-1:0]    px,
  input  logic signed [rrh_pkg::COORD_W-1:0]    py,
  input  logic        [rrh_pkg::CNT_W-1:0]      cnt_in,
  output logic        [rrh_pkg::CNT_W-1:0]      cnt_out
);
  import rrh_pkg::*;

  logic hit;
  logic sat;

  assign hit = (px >= rect.left) && (px <= rect.right) &&
               (py >= rect.bottom) && (py <= rect.top);
  assign sat = &cnt_in;

  assign cnt_out = (hit && !sat) ? cnt_in + CNT_W'(1) : cnt_in;

endmodule
`default_nettype wire

>>> design/rrh_bank.sv
// rrh_bank: rectangle bound memory and hit counter memory, registered reads
// depends on rrh_pkg
`default_nettype none
module rrh_bank #(
  parameter int NUM_QUERIES = 64,
  parameter int IW          = 6
) (
  input  logic                       clk,
  input  var rrh_pkg::bank_ctl_t     ctl,
  input  logic [IW-1:0]              rect_waddr,
  input  var rrh_pkg::rect_t         rect_wdata,
  input  logic [IW-1:0]              rect_raddr,
  output rrh_pkg::rect_t             rect_rdata,
  input  logic [IW-1:0]              cnt_waddr,
  input  logic [rrh_pkg::CNT_W-1:0]  cnt_wdata,
  input  logic [IW-1:0]              cnt_raddr,
  output logic [rrh_pkg::CNT_W-1:0]  cnt_rdata
);
  import rrh_pkg::*;

  rect_t            rect_mem [NUM_QUERIES];
  logic [CNT_W-1:0] cnt_mem  [NUM_QUERIES];

  always_ff @(posedge clk) begin
    if (ctl.rect_we) begin
      rect_mem[rect_waddr] <= rect_wdata;
    end
    rect_rdata <= rect_mem[rect_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

endmodule
`default_nettype wire

>>> design/rrh_ctrl.sv
// rrh_ctrl: sequencer for clearing, loading, point scans and counter reads
// depends on rrh_pkg; drives rrh_bank and feeds rrh_match
`default_nettype none
module rrh_ctrl #(
  parameter int NUM_QUERIES = 64,
  parameter int IW          = 6,
  parameter int LW          = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rrh_pkg::KIND_W-1:0]        in_kind,
  input  logic [rrh_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_point_ra,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_point_dec,
  input  logic                              cfg_we,
  input  logic [rrh_pkg::ACTIVE_W-1:0]      cfg_data,
  output rrh_pkg::bank_ctl_t                ctl,
  output logic [IW-1:0]                     rect_waddr,
  output logic [IW-1:0]                     rect_raddr,
  output logic [IW-1:0]                     cnt_waddr,
  output logic [IW-1:0]                     cnt_raddr,
  output logic signed [rrh_pkg::COORD_W-1:0] px,
  output logic signed [rrh_pkg::COORD_W-1:0] py,
  output logic                              rd_valid,
  output logic [rrh_pkg::SLOT_W-1:0]        rd_slot,
  output logic                              rd_slot_ok
);
  import rrh_pkg::*;

  state_t                    state_r, state_nxt;
  logic [LW-1:0]             q_r, q_nxt;
  logic [LW-1:0]             lim_r, lim_nxt;
  logic                      pv_r, pv_nxt;
  logic [IW-1:0]             pa_r, pa_nxt;
  logic [ACTIVE_W-1:0]       active_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      rd_valid_r;
  logic [SLOT_W-1:0]         rd_slot_r;
  logic                      rd_ok_r;

  logic          accept;
  logic [LW-1:0] slot_ext;
  logic          slot_ok;
  logic [LW-1:0] active_ext;
  logic [LW-1:0] lim_now;
  logic          scan_last;
  logic          clear_last;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign slot_ext   = LW'(in_slot);
  assign slot_ok    = slot_ext < LW'(NUM_QUERIES);
  assign active_ext = LW'(active_r);
  assign lim_now    = (active_ext > LW'(NUM_QUERIES)) ? LW'(NUM_QUERIES) : active_ext;
  assign scan_last  = (q_r + LW'(1)) == lim_r;
  assign clear_last = q_r == LW'(NUM_QUERIES - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_kind == KIND_POINT && lim_now != '0) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory controls and addresses
  always_comb begin
    ctl        = '0;
    rect_waddr = slot_ext[IW-1:0];
    rect_raddr = q_r[IW-1:0];
    cnt_waddr  = q_r[IW-1:0];
    cnt_raddr  = q_r[IW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ctl.cnt_we = 1'b1;
      end
      ST_IDLE: begin
        cnt_raddr = slot_ext[IW-1:0];
        if (accept && in_kind == KIND_LOAD && slot_ok) begin
          ctl.rect_we = 1'b1;
          ctl.cnt_we  = 1'b1;
          cnt_waddr   = slot_ext[IW-1:0];
        end
      end
      ST_SCAN, ST_DRAIN: begin
        // write back the counter for the rectangle read on the previous cycle
        if (pv_r) begin
          ctl.cnt_we = 1'b1;
          ctl.cnt_wb = 1'b1;
          cnt_waddr  = pa_r;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // scan counters and pipeline tag
  always_comb begin
    q_nxt   = q_r;
    lim_nxt = lim_r;
    pv_nxt  = 1'b0;
    pa_nxt  = pa_r;
    case (state_r)
      ST_CLEAR: begin
        q_nxt = clear_last ? '0 : q_r + LW'(1);
      end
      ST_IDLE: begin
        q_nxt   = '0;
        lim_nxt = lim_now;
      end
      ST_SCAN: begin
        pv_nxt = 1'b1;
        pa_nxt = q_r[IW-1:0];
        q_nxt  = scan_last ? '0 : q_r + LW'(1);
      end
      ST_DRAIN: begin
        q_nxt = '0;
      end
      default: begin
        q_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      q_r        <= '0;
      pv_r       <= 1'b0;
      active_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      q_r        <= q_nxt;
      pv_r       <= pv_nxt;
      rd_valid_r <= accept && in_kind == KIND_READ;
      if (cfg_we) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    pa_r  <= pa_nxt;
    if (accept && in_kind == KIND_POINT) begin
      px_r <= in_point_ra;
      py_r <= in_point_dec;
    end
    if (accept) begin
      rd_slot_r <= in_slot;
      rd_ok_r   <= slot_ok;
    end
  end

  assign px         = px_r;
  assign py         = py_r;
  assign rd_valid   = rd_valid_r;
  assign rd_slot    = rd_slot_r;
  assign rd_slot_ok = rd_ok_r;

endmodule
`default_nettype wire

>>> design/rectangle_range_hit_counter_unit.sv
// rectangle_range_hit_counter_unit: top level of the rectangle range hit counter
// load item: written on accept, no result. read item: result in the cycle after accept, no stall.
// point item: scans min(active_queries, NUM_QUERIES) rectangles (no scan when that is 0), then drains,
//   one counter read-modify-write per rectangle through the shared compare unit.
// reset: synchronous; a clearing pass then zeroes every counter while busy.
// results are shown on out_valid for one cycle; the receiver cannot hold them off.
`default_nettype none
module rectangle_range_hit_counter_unit #(
  parameter int NUM_QUERIES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rrh_pkg::KIND_W-1:0]         in_kind,
  input  logic [rrh_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_rect_left,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_rect_bottom,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_rect_right,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_rect_top,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_point_ra,
  input  logic signed [rrh_pkg::COORD_W-1:0] in_point_dec,
  output logic                               out_valid,
  output logic [rrh_pkg::SLOT_W-1:0]         out_count_slot,
  output logic [rrh_pkg::CNT_W-1:0]          out_hit_count,
  input  logic                               cfg_we,
  input  logic [rrh_pkg::ACTIVE_W-1:0]       cfg_data
);
  import rrh_pkg::*;

  localparam int IW = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;
  localparam int CW = $clog2(NUM_QUERIES + 1);
  localparam int LW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

  bank_ctl_t                 ctl;
  logic [IW-1:0]             rect_waddr, rect_raddr, cnt_waddr, cnt_raddr;
  rect_t                     rect_wdata, rect_rdata;
  logic [CNT_W-1:0]          cnt_rdata, cnt_upd, cnt_wdata;
  logic signed [COORD_W-1:0] px, py;
  logic                      rd_valid, rd_slot_ok;
  logic [SLOT_W-1:0]         rd_slot;

  assign rect_wdata.left   = in_rect_left;
  assign rect_wdata.bottom = in_rect_bottom;
  assign rect_wdata.right  = in_rect_right;
  assign rect_wdata.top    = in_rect_top;

  rrh_ctrl #(
    .NUM_QUERIES (NUM_QUERIES),
    .IW          (IW),
    .LW          (LW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_slot      (in_slot),
    .in_point_ra  (in_point_ra),
    .in_point_dec (in_point_dec),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .ctl          (ctl),
    .rect_waddr   (rect_waddr),
    .rect_raddr   (rect_raddr),
    .cnt_waddr    (cnt_waddr),
    .cnt_raddr    (cnt_raddr),
    .px           (px),
    .py           (py),
    .rd_valid     (rd_valid),
    .rd_slot      (rd_slot),
    .rd_slot_ok   (rd_slot_ok)
  );

  rrh_bank #(
    .NUM_QUERIES (NUM_QUERIES),
    .IW          (IW)
  ) u_bank (
    .clk        (clk),
    .ctl        (ctl),
    .rect_waddr (rect_waddr),
    .rect_wdata (rect_wdata),
    .rect_raddr (rect_raddr),
    .rect_rdata (rect_rdata),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata)
  );

  rrh_match u_match (
    .rect    (rect_rdata),
    .px      (px),
    .py      (py),
    .cnt_in  (cnt_rdata),
    .cnt_out (cnt_upd)
  );

  // clears and loads write zero
  assign cnt_wdata = ctl.cnt_wb ? cnt_upd : '0;

  assign out_valid      = rd_valid;
  assign out_count_slot = rd_slot;
  assign out_hit_count  = rd_slot_ok ? cnt_rdata : '0;

`ifndef NO_ASSERTIONS
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_kind == KIND_READ))
    else $error("result without an accepted read item");

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the sequencer is busy");

  a_idle_write_is_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cnt_we && !busy) |-> (start && in_kind == KIND_LOAD && !ctl.cnt_wb))
    else $error("counter written while idle without a load item");
`endif

endmodule
`default_nettype wire
